[sv/rectangle_placement_overlap_check_top_defines.svh]
// assertion macros used by the checker file
`ifndef RECTANGLE_PLACEMENT_OVERLAP_CHECK_TOP_DEFINES_SVH
`define RECTANGLE_PLACEMENT_OVERLAP_CHECK_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RPOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RPOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rpoc_pkg.sv]
package rpoc_pkg;

	// grid limits
	localparam int MAX_GRID_WIDTH  = 64;
	localparam int MAX_GRID_HEIGHT = 64;

	// field and register widths
	localparam int POS_W  = 8;
	localparam int SIZE_W = 7;
	localparam int DIM_W  = 7;
	localparam int ROW_W  = $clog2(MAX_GRID_HEIGHT);
	localparam int COL_W  = $clog2(MAX_GRID_WIDTH);
	localparam int IDX_W  = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	typedef logic [MAX_GRID_WIDTH-1:0] row_word_t;

endpackage

[sv/rectangle_placement_overlap_check_top.sv]
// Rectangle overlap checker on a grid of up to 64 x 64 cells. Each input
// transaction carries one rectangle; it returns exactly one result: whether
// this rectangle fits and whether the whole set fits so far. The occupancy
// bitmap lives in a 64-row memory that holds one 64-bit word per grid row,
// and a single row test / row mark unit walks it one row per cycle: first a
// check pass over the covered rows, then, if no cell collides, a mark pass.
// A new rectangle is taken only once the last verdict has moved into the
// output register, which waits on out_ready while it still holds a verdict;
// in_ready stays low meanwhile. first_of_set clears all row valid bits at
// once, so no clearing pass is needed. Grid size is written through wr_en /
// wr_index / wr_data while the block is idle, a rule the user must keep, as
// the block does not enforce it; sizes above 64 saturate to 64.
module rectangle_placement_overlap_check_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration writes
	input  logic                                 wr_en,
	input  logic [rpoc_pkg::IDX_W-1:0]           wr_index,
	input  logic [rpoc_pkg::DIM_W-1:0]           wr_data,
	// rectangle channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [rpoc_pkg::POS_W-1:0]    pos_x,
	input  logic signed [rpoc_pkg::POS_W-1:0]    pos_y,
	input  logic [rpoc_pkg::SIZE_W-1:0]          rect_width,
	input  logic [rpoc_pkg::SIZE_W-1:0]          rect_height,
	input  logic                                 first_of_set,
	input  logic                                 last_of_set,
	// verdict channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 item_fits,
	output logic                                 set_valid,
	output logic                                 set_done
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_CHKEND = 3'd2;
	localparam logic [2:0] ST_MARK   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [rpoc_pkg::DIM_W-1:0] MAX_W =
		rpoc_pkg::DIM_W'(rpoc_pkg::MAX_GRID_WIDTH);
	localparam logic [rpoc_pkg::DIM_W-1:0] MAX_H =
		rpoc_pkg::DIM_W'(rpoc_pkg::MAX_GRID_HEIGHT);

	logic [2:0]                     state_q;
	logic [rpoc_pkg::DIM_W-1:0]     grid_width_q;
	logic [rpoc_pkg::DIM_W-1:0]     grid_height_q;
	logic                           set_ok_q;
	logic [rpoc_pkg::MAX_GRID_HEIGHT-1:0] row_vld_q;
	logic [rpoc_pkg::ROW_W-1:0]     row_q;
	logic [rpoc_pkg::ROW_W-1:0]     row_start_q;
	logic [rpoc_pkg::SIZE_W-1:0]    rem_q;
	logic [rpoc_pkg::SIZE_W-1:0]    height_q;
	rpoc_pkg::row_word_t            mask_q;
	logic                           fits_q;
	logic                           hit_q;
	logic                           last_q;
	logic                           out_valid_q;
	logic                           item_fits_q;
	logic                           set_valid_q;
	logic                           set_done_q;

	// read stage of the bitmap memory
	rpoc_pkg::row_word_t            rd_data_s1;
	logic                           rd_vld_s1;
	logic                           rd_tag_s1;

	rpoc_pkg::row_word_t            row_mem [rpoc_pkg::MAX_GRID_HEIGHT];

	logic [rpoc_pkg::DIM_W-1:0]     gw;
	logic [rpoc_pkg::DIM_W-1:0]     gh;
	logic [rpoc_pkg::SIZE_W:0]      x_end;
	logic [rpoc_pkg::SIZE_W:0]      y_end;
	logic                           empty_rect;
	logic                           out_of_grid;
	rpoc_pkg::row_word_t            span;
	rpoc_pkg::row_word_t            new_mask;
	logic                           cur_hit;
	logic                           issue_rd;
	logic                           mark_wr;
	logic                           load_out;
	rpoc_pkg::row_word_t            wr_be;

	// saturated grid size
	assign gw = (grid_width_q > MAX_W) ? MAX_W : grid_width_q;
	assign gh = (grid_height_q > MAX_H) ? MAX_H : grid_height_q;

	// bounds test on the incoming rectangle
	assign x_end = {1'b0, pos_x[rpoc_pkg::POS_W-2:0]} + {1'b0, rect_width};
	assign y_end = {1'b0, pos_y[rpoc_pkg::POS_W-2:0]} + {1'b0, rect_height};
	assign empty_rect  = (rect_width == '0) || (rect_height == '0);
	assign out_of_grid = pos_x[rpoc_pkg::POS_W-1] || pos_y[rpoc_pkg::POS_W-1] ||
		(x_end > {1'b0, gw}) || (y_end > {1'b0, gh});

	// column mask of the rectangle
	assign span = rect_width[rpoc_pkg::SIZE_W-1] ? '1 :
		((rpoc_pkg::row_word_t'(1) << rect_width[rpoc_pkg::COL_W-1:0]) -
		rpoc_pkg::row_word_t'(1));
	assign new_mask = span << pos_x[rpoc_pkg::COL_W-1:0];

	// shared row test on the word read last cycle
	assign cur_hit = rd_tag_s1 && rd_vld_s1 && ((rd_data_s1 & mask_q) != '0);

	assign issue_rd = (state_q == ST_CHECK);
	assign mark_wr  = (state_q == ST_MARK);
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	// an invalid row is rewritten whole, a valid one only under the mask
	assign wr_be = row_vld_q[row_q] ? mask_q : '1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= MAX_W;
			grid_height_q <= MAX_H;
		end else if (wr_en) begin
			unique case (wr_index)
				rpoc_pkg::REG_GRID_WIDTH:  grid_width_q  <= wr_data;
				rpoc_pkg::REG_GRID_HEIGHT: grid_height_q <= wr_data;
				default: ;
			endcase
		end
	end

	// bitmap memory, one row per cycle
	always_ff @(posedge clk) begin
		if (issue_rd) begin
			rd_data_s1 <= row_mem[row_q];
		end
		if (mark_wr) begin
			for (int b = 0; b < rpoc_pkg::MAX_GRID_WIDTH; b++) begin
				if (wr_be[b]) begin
					row_mem[row_q][b] <= mask_q[b];
				end
			end
		end
	end

	// read tag and row valid of the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_tag_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_tag_s1 <= issue_rd;
			rd_vld_s1 <= row_vld_q[row_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_ok_q    <= 1'b1;
			row_vld_q   <= '0;
			row_q       <= '0;
			row_start_q <= '0;
			rem_q       <= '0;
			height_q    <= '0;
			mask_q      <= '0;
			fits_q      <= 1'b1;
			hit_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (first_of_set) begin
							row_vld_q <= '0;
							set_ok_q  <= 1'b1;
						end
						row_q       <= pos_y[rpoc_pkg::ROW_W-1:0];
						row_start_q <= pos_y[rpoc_pkg::ROW_W-1:0];
						rem_q       <= rect_height;
						height_q    <= rect_height;
						mask_q      <= new_mask;
						last_q      <= last_of_set;
						hit_q       <= 1'b0;
						if (empty_rect) begin
							fits_q  <= 1'b1;
							state_q <= ST_DONE;
						end else if (out_of_grid) begin
							fits_q  <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							fits_q  <= 1'b1;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					hit_q <= hit_q | cur_hit;
					row_q <= row_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == rpoc_pkg::SIZE_W'(1)) begin
						state_q <= ST_CHKEND;
					end
				end
				ST_CHKEND: begin
					if (hit_q || cur_hit) begin
						fits_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						row_q   <= row_start_q;
						rem_q   <= height_q;
						state_q <= ST_MARK;
					end
				end
				ST_MARK: begin
					row_vld_q[row_q] <= 1'b1;
					row_q <= row_q + 1'b1;
					rem_q <= rem_q - 1'b1;
					if (rem_q == rpoc_pkg::SIZE_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						set_ok_q <= set_ok_q & fits_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			item_fits_q <= fits_q;
			set_valid_q <= set_ok_q & fits_q;
			set_done_q  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign item_fits = item_fits_q;
	assign set_valid = set_valid_q;
	assign set_done  = set_done_q;

endmodule

[sv/rpoc_checker.sv]
`include "rectangle_placement_overlap_check_top_defines.svh"

module rpoc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic item_fits,
	input logic set_valid
);

	// a stalled result stays offered
	`RPOC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// one rectangle at a time: ready falls after each transaction
	`RPOC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready held after transaction")

	// a failing rectangle always fails its set
	`RPOC_ASSERT_NOW(a_fail_sticky, out_valid && !item_fits, !set_valid, "set valid with failing item")

endmodule

bind rectangle_placement_overlap_check_top rpoc_checker u_rpoc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.item_fits (item_fits),
	.set_valid (set_valid)
);

[bench/tb_rectangle_placement_overlap_check_top.sv]
module tb_rectangle_placement_overlap_check_top;
	timeunit 1ns;
	timeprecision 1ps;

	// one rectangle as it crosses the input channel
	typedef struct packed {
		logic signed [rpoc_pkg::POS_W-1:0] pos_x;
		logic signed [rpoc_pkg::POS_W-1:0] pos_y;
		logic [rpoc_pkg::SIZE_W-1:0]       rect_width;
		logic [rpoc_pkg::SIZE_W-1:0]       rect_height;
		logic                              first_of_set;
		logic                              last_of_set;
	} rect_t;

	typedef struct packed {
		logic fits;
		logic set_ok;
		logic done;
	} verdict_t;

	typedef struct packed {
		rect_t    rect;
		logic     typed;
		verdict_t want;
	} directed_row_t;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [rpoc_pkg::DIM_W-1:0] grid_w;
		logic [rpoc_pkg::DIM_W-1:0] grid_h;
		idle_mode_t                 mode;
		int                         count;
		logic                       pressure;
	} phase_t;

	localparam int NUM_DIRECTED = 25;
	localparam int NUM_PHASES   = 11;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 140;

	// directed rows on the 64 x 64 grid left by reset
	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{'{0, 0, 64, 64, 1, 0}, 1, '{1, 1, 0}},      // whole grid
		'{'{63, 63, 1, 1, 0, 0}, 1, '{0, 0, 0}},      // collides with full grid
		'{'{0, 0, 0, 5, 1, 0}, 1, '{1, 1, 0}},        // zero width
		'{'{-128, 0, 1, 1, 0, 0}, 1, '{0, 0, 0}},     // most negative column
		'{'{127, 127, 1, 1, 1, 0}, 1, '{0, 0, 0}},    // most positive corner
		'{'{-1, -1, 0, 0, 1, 0}, 1, '{1, 1, 0}},      // empty outside the grid
		'{'{0, 0, 127, 127, 1, 0}, 1, '{0, 0, 0}},    // oversized both ways
		'{'{0, 0, 65, 1, 1, 0}, 1, '{0, 0, 0}},       // one column too wide
		'{'{63, 0, 1, 64, 1, 0}, 1, '{1, 1, 0}},      // right edge column
		'{'{62, 0, 2, 1, 0, 0}, 1, '{0, 0, 0}},       // clips the edge column
		'{'{0, 63, 63, 1, 1, 0}, 1, '{1, 1, 0}},      // bottom row
		'{'{0, 0, 63, 63, 0, 1}, 1, '{1, 1, 1}},      // fills the square above the bottom row
		'{'{1, 1, 1, 1, 0, 0}, 1, '{0, 0, 0}},        // set continues without a start
		'{'{10, 10, 0, 3, 0, 1}, 1, '{1, 0, 1}},      // empty, set stays failed
		'{'{5, 5, 3, 4, 1, 1}, 1, '{1, 1, 1}},        // single-item set
		'{'{6, 6, 1, 1, 1, 0}, 1, '{1, 1, 0}},        // start clears the bitmap
		'{'{-128, -128, 0, 64, 0, 0}, 1, '{1, 1, 0}}, // empty at the far corner
		'{'{64, 0, 1, 1, 0, 0}, 1, '{0, 0, 0}},       // one column past the edge
		'{'{0, -1, 1, 1, 1, 0}, 1, '{0, 0, 0}},       // one row above the grid
		'{'{0, 0, 1, 1, 0, 0}, 1, '{1, 0, 0}},        // fits but set already failed
		'{'{20, 30, 7, 9, 1, 0}, 0, '0},
		'{'{25, 35, 10, 2, 0, 0}, 0, '0},
		'{'{27, 39, 37, 25, 0, 1}, 0, '0},
		'{'{0, 0, 64, 1, 0, 1}, 0, '0},
		'{'{127, -128, 127, 127, 1, 1}, 0, '0}
	};

	// grid size, idling, item count and hold-off request of each random phase
	localparam phase_t PHASES [NUM_PHASES] = '{
		'{64, 64, IDLE_NONE, 110, 0},
		'{1, 1, IDLE_SEND, 50, 0},
		'{64, 1, IDLE_RECV, 70, 1},
		'{1, 64, IDLE_BOTH, 70, 0},
		'{0, 17, IDLE_NONE, 30, 0},
		'{127, 127, IDLE_SEND, 100, 0},
		'{40, 23, IDLE_RECV, 100, 0},
		'{9, 64, IDLE_BOTH, 100, 1},
		'{64, 0, IDLE_NONE, 30, 0},
		'{13, 5, IDLE_BOTH, 70, 0},
		'{64, 64, IDLE_RECV, 70, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [rpoc_pkg::IDX_W-1:0] wr_index = '0;
	logic [rpoc_pkg::DIM_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [rpoc_pkg::POS_W-1:0] pos_x = '0;
	logic signed [rpoc_pkg::POS_W-1:0] pos_y = '0;
	logic [rpoc_pkg::SIZE_W-1:0] rect_width = '0;
	logic [rpoc_pkg::SIZE_W-1:0] rect_height = '0;
	logic first_of_set = 1'b0;
	logic last_of_set = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic item_fits;
	logic set_valid;
	logic set_done;

	// handshakes and verdict seen at the falling edge, used at the next rising edge
	logic in_take = 1'b0;
	logic out_take = 1'b0;
	verdict_t got = '0;

	// mirror of the block state and its registers
	rpoc_pkg::row_word_t occ_rows [rpoc_pkg::MAX_GRID_HEIGHT] = '{default: '0};
	logic set_ok = 1'b1;
	logic [rpoc_pkg::DIM_W-1:0] cfg_w = 7'd64;
	logic [rpoc_pkg::DIM_W-1:0] cfg_h = 7'd64;

	verdict_t expected_verdicts [$];
	int mismatch_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	logic hold_request = 1'b0;

	rectangle_placement_overlap_check_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.first_of_set (first_of_set),
		.last_of_set  (last_of_set),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.item_fits    (item_fits),
		.set_valid    (set_valid),
		.set_done     (set_done)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		in_take = arst_n && in_valid && in_ready;
		out_take = arst_n && out_valid && out_ready;
		got = '{item_fits, set_valid, set_done};
	end

	// clear the bitmap on a set start, check the rectangle against it, mark it if it fits
	function automatic verdict_t place_rect(rect_t r);
		int x, y, w, h, gw, gh, row;
		rpoc_pkg::row_word_t span, mask;
		logic fits;
		verdict_t v;
		x = $signed(r.pos_x);
		y = $signed(r.pos_y);
		w = r.rect_width;
		h = r.rect_height;
		gw = (cfg_w > rpoc_pkg::MAX_GRID_WIDTH) ? rpoc_pkg::MAX_GRID_WIDTH : cfg_w;
		gh = (cfg_h > rpoc_pkg::MAX_GRID_HEIGHT) ? rpoc_pkg::MAX_GRID_HEIGHT : cfg_h;
		fits = 1'b1;
		if (r.first_of_set) begin
			for (row = 0; row < rpoc_pkg::MAX_GRID_HEIGHT; row++)
				occ_rows[row] = '0;
			set_ok = 1'b1;
		end
		if (w != 0 && h != 0) begin
			if (x < 0 || y < 0 || x + w > gw || y + h > gh) begin
				fits = 1'b0;
			end else begin
				span = (w >= rpoc_pkg::MAX_GRID_WIDTH) ? '1 :
					((rpoc_pkg::row_word_t'(1) << w) - 1);
				mask = span << x;
				for (row = y; row < y + h; row++)
					if ((occ_rows[row] & mask) != '0)
						fits = 1'b0;
				// a failing rectangle marks nothing
				if (fits)
					for (row = y; row < y + h; row++)
						occ_rows[row] = occ_rows[row] | mask;
			end
		end
		if (!fits)
			set_ok = 1'b0;
		v.fits = fits;
		v.set_ok = set_ok;
		v.done = r.last_of_set;
		return v;
	endfunction

	// rectangle mostly inside the current grid, sometimes just over an edge
	function automatic rect_t placed_rect(logic opens, logic closes);
		int gw, gh, x, y, w, h;
		rect_t r;
		gw = (cfg_w == 0 || cfg_w > rpoc_pkg::MAX_GRID_WIDTH) ?
			rpoc_pkg::MAX_GRID_WIDTH : cfg_w;
		gh = (cfg_h == 0 || cfg_h > rpoc_pkg::MAX_GRID_HEIGHT) ?
			rpoc_pkg::MAX_GRID_HEIGHT : cfg_h;
		x = $urandom_range(0, gw - 1);
		y = $urandom_range(0, gh - 1);
		w = $urandom_range(1, (gw - x < 10) ? gw - x : 10);
		h = $urandom_range(1, (gh - y < 5) ? gh - y : 5);
		case ($urandom_range(0, 19))
			0: w = 0;
			1: h = 0;
			2: w = gw - x + 1;
			3: h = gh - y + 1;
			4: h = gh - y;
			5: w = gw - x;
			default: ;
		endcase
		r.pos_x = rpoc_pkg::POS_W'(x);
		r.pos_y = rpoc_pkg::POS_W'(y);
		r.rect_width = rpoc_pkg::SIZE_W'(w);
		r.rect_height = rpoc_pkg::SIZE_W'(h);
		r.first_of_set = opens;
		r.last_of_set = closes;
		return r;
	endfunction

	// offer one rectangle, record the verdict it should produce
	task automatic send_rect(rect_t r, logic typed, verdict_t want);
		verdict_t predicted;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= r.pos_x;
		pos_y <= r.pos_y;
		rect_width <= r.rect_width;
		rect_height <= r.rect_height;
		first_of_set <= r.first_of_set;
		last_of_set <= r.last_of_set;
		do @(posedge clk); while (!in_take);
		predicted = place_rect(r);
		expected_verdicts.push_back(typed ? want : predicted);
	endtask

	// sets, most opened by a start, with some stray random transactions between them
	task automatic run_random(int count);
		int sent, n, k;
		rect_t r;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 12) begin
				r.pos_x = rpoc_pkg::POS_W'($urandom);
				r.pos_y = rpoc_pkg::POS_W'($urandom);
				r.rect_width = rpoc_pkg::SIZE_W'($urandom);
				r.rect_height = rpoc_pkg::SIZE_W'($urandom);
				r.first_of_set = 1'($urandom);
				r.last_of_set = 1'($urandom);
				send_rect(r, 1'b0, '0);
				sent++;
			end else begin
				n = $urandom_range(1, 8);
				for (k = 0; k < n; k++) begin
					r = placed_rect(k == 0 && $urandom_range(9) != 0, k == n - 1);
					send_rect(r, 1'b0, '0);
					sent++;
				end
			end
		end
	endtask

	task automatic write_reg(logic [rpoc_pkg::IDX_W-1:0] index,
			logic [rpoc_pkg::DIM_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= value;
		@(posedge clk);
		if (index == rpoc_pkg::REG_GRID_WIDTH)
			cfg_w = value;
		else
			cfg_h = value;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_gap_pct = 57;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_gap_pct = 0;
				recv_stall_pct = 57;
			end
			default: begin
				send_gap_pct = 30;
				recv_stall_pct = 30;
			end
		endcase
	endtask

	// stimulus: reset, directed rows, then random phases
	initial begin : stimulus
		int i, p;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idle(IDLE_NONE);
		for (i = 0; i < NUM_DIRECTED; i++)
			send_rect(DIRECTED_ROWS[i].rect, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_reg(rpoc_pkg::REG_GRID_WIDTH, PHASES[p].grid_w);
			write_reg(rpoc_pkg::REG_GRID_HEIGHT, PHASES[p].grid_h);
			wr_en <= 1'b0;
			set_idle(PHASES[p].mode);
			if (PHASES[p].pressure)
				hold_request = 1'b1;
			run_random(PHASES[p].count);
		end
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		mismatch_count += expected_verdicts.size();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// compare each verdict transaction with the oldest expectation
	initial begin : verdict_check
		verdict_t want;
		forever begin
			@(posedge clk);
			if (out_take) begin
				if (expected_verdicts.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("verdict with none expected: fits=%0b set_valid=%0b set_done=%0b",
							got.fits, got.set_ok, got.done);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.fits !== want.fits || got.set_ok !== want.set_ok ||
							got.done !== want.done) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("verdict mismatch: expected %0b/%0b/%0b got %0b/%0b/%0b %s",
								want.fits, want.set_ok, want.done,
								got.fits, got.set_ok, got.done,
								"(fits/set_valid/set_done)");
					end
				end
			end
		end
	end

	// end the run when no transaction moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (in_take || out_take)
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
